/* rtl/tplf_pkg.sv */
// ----------------------------------------------------------------------------
// tplf_pkg
// Shared types and constants of the two-port learning forwarder.
// ----------------------------------------------------------------------------
package tplf_pkg;

    localparam int MAC_W    = 48;
    localparam int ADDR_W   = 16;
    localparam int MARKER_W = 24;
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 6;
    localparam int KIND_W   = 2;

    localparam logic [MAC_W-1:0]    BCAST_MAC = {MAC_W{1'b1}};
    localparam logic [MARKER_W-1:0] MARK_CODE = 24'h232323;

    // command kinds handed from front to back
    localparam logic [KIND_W-1:0] KIND_LEARN  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;

    // result action codes
    localparam logic [ACTION_W-1:0] ACT_LEARNED = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_KNOWN   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FULL    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DROPPED = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_FWD     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_NOROUTE = 3'd5;

    // configuration register indexes
    localparam logic REG_OWN_MAC0 = 1'b0;
    localparam logic REG_OWN_MAC1 = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              port;   // table to search or fill
        logic [ADDR_W-1:0] key;    // address searched for
        logic [MAC_W-1:0]  mac;    // MAC to learn
    } cmd_t;

endpackage

/* rtl/tplf_front.sv */
// ----------------------------------------------------------------------------
// tplf_front
// Accepts frame headers and classifies them into learn, lookup or drop.
// ----------------------------------------------------------------------------
module tplf_front
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [151:0]          s_tdata,   // dest_mac, src_mac, dest_addr, src_addr, marker
    input  logic                  s_tuser,   // arrival_port
    input  logic [47:0]           own_mac0,
    input  logic [47:0]           own_mac1,
    input  logic                  q_full,
    output logic                  q_push,
    output tplf_pkg::cmd_t        q_cmd
);
    import tplf_pkg::*;

    logic [MAC_W-1:0]    dest_mac;
    logic [MAC_W-1:0]    src_mac;
    logic [ADDR_W-1:0]   dest_addr;
    logic [ADDR_W-1:0]   src_addr;
    logic [MARKER_W-1:0] marker;
    logic [MAC_W-1:0]    own_mac;

    assign dest_mac  = s_tdata[47:0];
    assign src_mac   = s_tdata[95:48];
    assign dest_addr = s_tdata[111:96];
    assign src_addr  = s_tdata[127:112];
    assign marker    = s_tdata[151:128];
    assign own_mac   = s_tuser ? own_mac1 : own_mac0;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        q_cmd.mac = src_mac;
        priority if (dest_mac == BCAST_MAC && marker == MARK_CODE)
        begin
            q_cmd.kind = KIND_LEARN;
            q_cmd.port = s_tuser;
            q_cmd.key  = src_addr;
        end
        else if (dest_mac != own_mac)
        begin
            q_cmd.kind = KIND_DROP;
            q_cmd.port = s_tuser;
            q_cmd.key  = dest_addr;
        end
        else
        begin
            // search the table of the other port
            q_cmd.kind = KIND_LOOKUP;
            q_cmd.port = !s_tuser;
            q_cmd.key  = dest_addr;
        end
    end

endmodule

/* rtl/tplf_queue.sv */
// ----------------------------------------------------------------------------
// tplf_queue
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module tplf_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tplf_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output tplf_pkg::cmd_t pop_cmd
);
    import tplf_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;

    assign full    = (fill_reg == 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/tplf_back.sv */
// ----------------------------------------------------------------------------
// tplf_back
// Table engine: sequential search, learning and forwarding per command.
// ----------------------------------------------------------------------------
module tplf_back
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  tplf_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [55:0]    m_tdata,   // new_dest_mac, entry_index
    output logic [3:0]     m_tuser    // action, out_port
);
    import tplf_pkg::*;

    localparam int IW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW    = $clog2(TABLE_ENTRIES + 1);
    localparam int DEPTH = 2 * (2 ** IW);
    localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_MAC    = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [ADDR_W-1:0] addr_mem [DEPTH];
    logic [MAC_W-1:0]  mac_mem  [DEPTH];

    logic [1:0]          state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]       count_reg [2];
    logic [CW-1:0]       count_next [2];
    logic [ACTION_W-1:0] res_action_reg, res_action_next;
    logic                res_port_reg, res_port_next;
    logic [MAC_W-1:0]    res_mac_reg, res_mac_next;
    logic [IW-1:0]       res_idx_reg, res_idx_next;

    logic [ADDR_W-1:0]   addr_rd_reg;
    logic [MAC_W-1:0]    mac_rd_reg;
    logic [CW-1:0]       count_cur;
    logic                hit;
    logic                wr_en;
    logic [IW:0]         wr_addr;
    logic [IW+5:0]       idx_wide;

    assign count_cur = count_reg[cmd_reg.port];
    assign hit       = cmp_valid_reg && (addr_rd_reg == cmd_reg.key);
    assign wr_addr   = {cmd_reg.port, count_cur[IW-1:0]};

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        scan_next       = scan_reg;
        cmp_valid_next  = cmp_valid_reg;
        cmp_idx_next    = cmp_idx_reg;
        count_next[0]   = count_reg[0];
        count_next[1]   = count_reg[1];
        res_action_next = res_action_reg;
        res_port_next   = res_port_reg;
        res_mac_next    = res_mac_reg;
        res_idx_next    = res_idx_reg;
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cmd_next       = q_cmd;
                    scan_next      = '0;
                    cmp_valid_next = 1'b0;
                    res_port_next  = 1'b0;
                    res_mac_next   = '0;
                    res_idx_next   = '0;
                    if (q_cmd.kind == KIND_DROP)
                    begin
                        res_action_next = ACT_DROPPED;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                cmp_valid_next = 1'b0;
                priority if (hit)
                begin
                    res_idx_next = cmp_idx_reg;
                    if (cmd_reg.kind == KIND_LEARN)
                    begin
                        res_action_next = ACT_KNOWN;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        res_action_next = ACT_FWD;
                        res_port_next   = cmd_reg.port;
                        state_next      = ST_MAC;
                    end
                end
                else if (scan_reg < count_cur)
                begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_reg[IW-1:0];
                    scan_next      = scan_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_DONE;
                    if (cmd_reg.kind == KIND_LEARN)
                    begin
                        if (count_cur >= FULL_COUNT)
                        begin
                            res_action_next = ACT_FULL;
                        end
                        else
                        begin
                            wr_en                    = 1'b1;
                            res_action_next          = ACT_LEARNED;
                            res_idx_next             = count_cur[IW-1:0];
                            count_next[cmd_reg.port] = count_cur + CW'(1);
                        end
                    end
                    else
                    begin
                        res_action_next = ACT_NOROUTE;
                    end
                end
            end
            ST_MAC:
            begin
                res_mac_next = mac_rd_reg;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            count_reg[0]  <= '0;
            count_reg[1]  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg[0]  <= count_next[0];
            count_reg[1]  <= count_next[1];
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        scan_reg       <= scan_next;
        cmp_idx_reg    <= cmp_idx_next;
        res_action_reg <= res_action_next;
        res_port_reg   <= res_port_next;
        res_mac_reg    <= res_mac_next;
        res_idx_reg    <= res_idx_next;
    end

    // table memories, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            addr_mem[wr_addr] <= cmd_reg.key;
            mac_mem[wr_addr]  <= cmd_reg.mac;
        end
        addr_rd_reg <= addr_mem[{cmd_reg.port, scan_reg[IW-1:0]}];
        mac_rd_reg  <= mac_mem[{cmd_reg.port, cmp_idx_reg}];
    end

    assign idx_wide = {6'b0, res_idx_reg};
    assign m_tvalid = (state_reg == ST_DONE);
    assign m_tdata  = {2'b00, idx_wide[5:0], res_mac_reg};
    assign m_tuser  = {res_port_reg, res_action_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[0] <= FULL_COUNT) && (count_reg[1] <= FULL_COUNT))
        else $error("table count beyond capacity");

    a_mac_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> ($past(state_reg) == ST_SEARCH && $past(hit)))
        else $error("MAC read without a preceding hit");

    a_learn_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (state_reg == ST_DONE && res_action_reg == ACT_LEARNED))
        else $error("table write without learned result");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH && cmp_valid_reg) |-> ({1'b0, cmp_idx_reg} < {1'b0, count_cur}))
        else $error("compare of entry beyond count");
`endif

endmodule

/* rtl/two_port_learning_forwarder.sv */
// ----------------------------------------------------------------------------
// two_port_learning_forwarder
// Learning address table for a two-port forwarder, one table per port.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries one frame header per transfer: s_tuser is the
//   arrival port, s_tdata holds dest_mac, src_mac, dest_addr, src_addr and
//   the marker. m_* stream returns one result per header: m_tuser holds
//   action and out_port, m_tdata holds new_dest_mac and entry_index.
//   cfg_we/cfg_index/cfg_data write the own MAC of port 0 or port 1; write
//   only while the block is idle.
// Timing:
//   A header is classified on transfer and waits in a two-entry queue.
//   The table engine searches a header against a table holding n entries
//   (at most TABLE_ENTRIES) with one address-memory read per cycle over the
//   valid entries; a dropped header skips the search. Headers are worked
//   one at a time.
// Reset:
//   Clears both table counts and the own MACs; table contents need no clear.
// Stall:
//   With m_tready low the result holds; the queue still takes up to two
//   more headers, then s_tready drops.
// ----------------------------------------------------------------------------
module two_port_learning_forwarder
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [151:0] s_tdata,   // dest_mac, src_mac, dest_addr, src_addr, marker
    input  logic         s_tuser,   // arrival_port
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // new_dest_mac, entry_index
    output logic [3:0]   m_tuser,   // action, out_port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data
);
    import tplf_pkg::*;

    logic [MAC_W-1:0] own_mac0_reg;
    logic [MAC_W-1:0] own_mac1_reg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    // hold the own MACs; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac0_reg <= '0;
            own_mac1_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_OWN_MAC0: own_mac0_reg <= cfg_data;
                REG_OWN_MAC1: own_mac1_reg <= cfg_data;
                default:      own_mac0_reg <= own_mac0_reg;
            endcase
        end
    end

    // classify each header on transfer
    tplf_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .own_mac0 (own_mac0_reg),
        .own_mac1 (own_mac1_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    // decouple front from the table engine
    tplf_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (pop_cmd)
    );

    // search, learn and forward
    tplf_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
